FILE: hdl/dwpi_pkg.sv
// Package for the double-ended queue with positional insert.
// Holds command and status codes, fixed port widths and the cell control struct.
// No dependencies.
`default_nettype none

package dwpi_pkg;

  localparam int unsigned DWPI_CMD_W = 3;
  localparam int unsigned DWPI_POS_W = 5;
  localparam int unsigned DWPI_VAL_W = 32;
  localparam int unsigned DWPI_CNT_W = 5;

  typedef enum logic [DWPI_CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4
  } dwpi_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } dwpi_status_e;

  typedef struct packed {
    logic load;
    logic take_prev;
    logic take_next;
  } dwpi_cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/dwpi_cell.sv
// One storage cell of the queue chain: loads a new word or takes its neighbor's word.
// Depends on dwpi_pkg for the cell control struct.
`default_nettype none

module dwpi_cell
  import dwpi_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic                 clk_i,
  input  dwpi_cell_ctl_t       ctl_i,
  input  logic [WIDTH-1:0]     value_i,
  input  logic [WIDTH-1:0]     prev_i,
  input  logic [WIDTH-1:0]     next_i,
  output logic [WIDTH-1:0]     data_o
);

  logic [WIDTH-1:0] data_d;
  logic [WIDTH-1:0] data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = value_i;
    end else if (ctl_i.take_prev) begin
      data_d = prev_i;
    end else if (ctl_i.take_next) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: hdl/deque_with_positional_insert.sv
// Top level of the bounded double-ended queue with positional insert.
// Depends on dwpi_pkg and instantiates one dwpi_cell per entry.
//
// The queue keeps up to DEPTH words of WIDTH bits front-first in a chain of
// cells. It takes one request per clock cycle while ready: every cell updates
// in the same cycle (shift up for an insert or front push, shift down for a
// front pop), and the result is registered, so it appears in the cycle after
// acceptance. A new request is taken whenever the output register is empty or
// its result is being taken in that cycle. The request port holds 32-bit words
// of which the low WIDTH bits are stored; popped words are zero-extended or
// truncated to 32 bits and the count port shows the low 5 bits of the count.
// Storage needs no clearing after reset; only entries below the count are read.
`default_nettype none

module deque_with_positional_insert
  import dwpi_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DWPI_CMD_W-1:0] cmd_i,
  input  logic [DWPI_POS_W-1:0] position_i,
  input  logic [DWPI_VAL_W-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DWPI_VAL_W-1:0] popped_value_o,
  output logic [1:0]            status_o,
  output logic [DWPI_CNT_W-1:0] count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CmpW = (CntW > DWPI_POS_W) ? CntW : DWPI_POS_W;

  logic                  accept;
  logic [CntW-1:0]       count_d, count_q;
  logic                  out_valid_d, out_valid_q;
  logic [DWPI_VAL_W-1:0] popped_d, popped_q;
  dwpi_status_e          status_d, status_q;

  logic                  full, empty;
  logic                  do_ins, do_popf, do_popb;
  logic [CntW-1:0]       ins_pos;
  logic [CntW-1:0]       last_pos;
  logic [IdxW-1:0]       back_idx;
  logic [WIDTH-1:0]      word_in;
  logic [WIDTH-1:0]      pop_word;

  logic [WIDTH-1:0]      cell_data [DEPTH];
  logic [WIDTH-1:0]      cell_prev [DEPTH];
  logic [WIDTH-1:0]      cell_next [DEPTH];
  dwpi_cell_ctl_t        cell_ctl  [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full     = (count_q == CntW'(DEPTH));
  assign empty    = (count_q == '0);
  assign word_in  = WIDTH'(value_i);
  assign last_pos = count_q - CntW'(1);
  assign back_idx = last_pos[IdxW-1:0];

  always_comb begin
    do_ins   = 1'b0;
    do_popf  = 1'b0;
    do_popb  = 1'b0;
    ins_pos  = '0;
    status_d = ST_OK;
    case (dwpi_cmd_e'(cmd_i))
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins = accept;
        end
      end
      CMD_PUSH_BACK: begin
        ins_pos = count_q;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins = accept;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          do_popf = accept;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          do_popb = accept;
        end
      end
      CMD_INSERT: begin
        ins_pos = CntW'(position_i);
        if (CmpW'(position_i) > CmpW'(count_q)) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins = accept;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_comb begin
    pop_word = '0;
    if (do_popf) begin
      pop_word = cell_data[0];
    end else if (do_popb) begin
      pop_word = cell_data[back_idx];
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_popf || do_popb) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign popped_d    = DWPI_VAL_W'(pop_word);
  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_prev[i] = '0;
    end else begin : g_prev
      assign cell_prev[i] = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign cell_next[i] = cell_data[i];
    end else begin : g_next
      assign cell_next[i] = cell_data[i+1];
    end

    assign cell_ctl[i].load      = do_ins && (ins_pos == CntW'(i));
    assign cell_ctl[i].take_prev = do_ins && (CntW'(i) > ins_pos);
    assign cell_ctl[i].take_next = do_popf;

    dwpi_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[i]),
      .value_i (word_in),
      .prev_i  (cell_prev[i]),
      .next_i  (cell_next[i]),
      .data_o  (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  logic [DWPI_CNT_W-1:0] count_out_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      count_out_q <= DWPI_CNT_W'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign count_o        = count_out_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("count exceeds depth");

  a_ins_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the count");

  a_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && empty && (cmd_i == CMD_POP_FRONT || cmd_i == CMD_POP_BACK)
    |=> status_q == ST_EMPTY && count_q == '0 && popped_q == '0)
    else $error("pop on empty list misreported");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (cmd_i == CMD_PUSH_FRONT || cmd_i == CMD_PUSH_BACK)
    |=> status_q == ST_FULL && count_q == $past(count_q))
    else $error("push on full list not rejected");
`endif

endmodule

`default_nettype wire
